@@ design/sus_pkg.sv @@
// sus_pkg: shared types and constants of the small unordered set
// operation and status codes, word layouts, cell control bundle
// depends on nothing
`timescale 1ns / 1ps

package sus_pkg;

	// fixed field widths of the request and response words
	localparam int MODE_W     = 2;
	localparam int KEY_W      = 32;
	localparam int POS_W      = 4;
	localparam int CNT_OUT_W  = 5;
	localparam int STATUS_W   = 2;
	localparam int POS_SPAN   = 2 ** POS_W;

	// defaults for the top-level parameters
	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		mode_t             mode;
		logic [KEY_W-1:0]  key;
		logic [POS_W-1:0]  position;
	} sus_req_t;

	typedef struct packed {
		logic                 found;
		logic [KEY_W-1:0]     read_value;
		logic [CNT_OUT_W-1:0] entry_count;
		status_t              status;
	} sus_rsp_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic cmp;   // latch compare and position match
		logic ins;   // first free cell takes the key
		logic rem;   // cells at or above the slot take their neighbor
	} sus_cell_ctl_t;

endpackage

@@ design/sus_req_if.sv @@
// sus_req_if: request channel of the small unordered set
// valid/ready handshake carrying one request word; depends on sus_pkg
`timescale 1ns / 1ps

interface sus_req_if import sus_pkg::*; ();
	logic     valid;
	logic     ready;
	sus_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sus_rsp_if.sv @@
// sus_rsp_if: response channel of the small unordered set
// valid/ready handshake carrying one response word; depends on sus_pkg
`timescale 1ns / 1ps

interface sus_rsp_if import sus_pkg::*; ();
	logic     valid;
	logic     ready;
	sus_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/small_unordered_set.sv @@
// small_unordered_set: top level, a row of key cells with compare and update stages
// depends on sus_pkg, sus_req_if, sus_rsp_if and sus_cell
`timescale 1ns / 1ps

// Set of up to CAPACITY distinct keys kept in insertion order.
// req: one word per operation (mode, key, position); rsp: one word per request
// (found, read_value, entry_count, status), returned in request order.
// Modes: insert appends an absent key, remove deletes a key and the later
// cells shift down one place, query reports membership, read returns the
// key at a position. Keys are compared in their low KEY_WIDTH bits.
// Every cell compares its key in the accepting cycle and registers the result;
// the row is updated when the word leaves the compare stage. A new word is
// taken once the compare stage has moved on.
// The response sits in an output register; while it waits, one further word
// can be taken into the compare stage. If the receiver holds ready low,
// that word waits there and req.ready stays low until the response drains.
// Reset empties the set at once (all occupied flags and the count clear);
// no clearing pass is needed and the block accepts words right after reset.
module small_unordered_set import sus_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sus_req_if.sink    req,
	sus_rsp_if.source  rsp
);

	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int SLOT_W  = $clog2(CAPACITY);
	localparam int KEY_EXT = (KEY_WIDTH > KEY_W) ? KEY_WIDTH : KEY_W;
	localparam int CNT_EXT = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	logic                 accept;
	logic                 adv;
	logic                 s1_valid_q;
	mode_t                mode_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic [KEY_WIDTH-1:0] cmp_key;
	logic [KEY_EXT-1:0]   key_in_ext;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 full;
	logic                 found;
	logic                 any_sel;
	logic [SLOT_W-1:0]    slot;
	logic [KEY_WIDTH-1:0] rd_key;
	logic [KEY_EXT-1:0]   rd_ext;
	logic [CNT_EXT-1:0]   cnt_ext;
	status_t              status_nxt;
	sus_cell_ctl_t        ctl;
	logic                 rsp_valid_q;
	sus_rsp_t             rsp_q;

	logic [CAPACITY-1:0]  occ_vec;
	logic [CAPACITY-1:0]  hit_vec;
	logic [CAPACITY-1:0]  sel_vec;
	logic [KEY_WIDTH-1:0] entry_arr [CAPACITY];

	// handshake: one word in the compare stage at a time
	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && !s1_valid_q;
	assign adv       = s1_valid_q && (!rsp_valid_q || rsp.ready);

	// incoming key reduced to the compared width
	assign key_in_ext = KEY_EXT'(req.data.key);
	assign cmp_key    = key_in_ext[KEY_WIDTH-1:0];

	// compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= req.data.mode;
			key_s1  <= cmp_key;
		end
	end

	// hit slot, membership and read selection over the row
	always_comb begin
		slot   = '0;
		rd_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) begin
				slot = slot | SLOT_W'(i);
			end
			rd_key = rd_key | (entry_arr[i] & {KEY_WIDTH{sel_vec[i]}});
		end
	end

	assign found   = (|hit_vec) && (mode_s1 != MODE_READ);
	assign any_sel = |sel_vec;
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign rd_ext  = KEY_EXT'(rd_key);

	// cell commands
	always_comb begin
		ctl.cmp = accept;
		ctl.ins = adv && (mode_s1 == MODE_INSERT) && !found;
		ctl.rem = adv && (mode_s1 == MODE_REMOVE) && found;
	end

	// next count and status
	always_comb begin
		count_nxt  = count_q;
		status_nxt = STATUS_OK;
		unique case (mode_s1)
			MODE_INSERT: begin
				if (!found) begin
					if (full) begin
						status_nxt = STATUS_FULL;
					end else begin
						count_nxt = count_q + CNT_W'(1);
					end
				end
			end
			MODE_REMOVE: begin
				if (found) begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			MODE_QUERY: begin
				count_nxt = count_q;
			end
			MODE_READ: begin
				if (!any_sel) begin
					status_nxt = STATUS_RANGE;
				end
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	assign cnt_ext = CNT_EXT'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv) begin
			count_q <= count_nxt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.found       <= found;
			rsp_q.read_value  <= (mode_s1 == MODE_READ) ? rd_ext[KEY_W-1:0] : '0;
			rsp_q.entry_count <= cnt_ext[CNT_OUT_W-1:0];
			rsp_q.status      <= status_nxt;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                 prev_occ;
		logic                 nxt_occ;
		logic [KEY_WIDTH-1:0] nxt_entry;

		if (g == 0) begin : g_first
			assign prev_occ = 1'b1;
		end else begin : g_mid
			assign prev_occ = occ_vec[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign nxt_occ   = 1'b0;
			assign nxt_entry = entry_arr[g];
		end else begin : g_inner
			assign nxt_occ   = occ_vec[g+1];
			assign nxt_entry = entry_arr[g+1];
		end

		sus_cell #(
			.KEY_WIDTH (KEY_WIDTH),
			.SLOT_W    (SLOT_W),
			.IDX       (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cmp_key   (cmp_key),
			.ld_key    (key_s1),
			.position  (req.data.position),
			.slot      (slot),
			.prev_occ  (prev_occ),
			.nxt_occ   (nxt_occ),
			.nxt_entry (nxt_entry),
			.occ       (occ_vec[g]),
			.entry     (entry_arr[g]),
			.hit       (hit_vec[g]),
			.sel       (sel_vec[g])
		);
	end

`ifndef SYNTH
	// count never goes past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	// occupied cells always match the count
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == int'(count_q))
		else $error("occupancy and count disagree");

	// keys are distinct, so at most one cell hits
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(hit_vec))
		else $error("duplicate key in set");

	// a dropped insert leaves the set full
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (mode_s1 == MODE_INSERT) && (status_nxt == STATUS_FULL))
		|=> (count_q == CNT_W'(CAPACITY)))
		else $error("dropped insert changed the count");
`endif

endmodule

@@ design/sus_cell.sv @@
// sus_cell: one slot of the set, holding a key and its occupied flag
// compares against the broadcast key and shifts down from its upper neighbor
// depends on sus_pkg
`timescale 1ns / 1ps

module sus_cell import sus_pkg::*; #(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int SLOT_W    = 4,
	parameter int IDX       = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sus_cell_ctl_t        ctl,
	input  logic [KEY_WIDTH-1:0] cmp_key,
	input  logic [KEY_WIDTH-1:0] ld_key,
	input  logic [POS_W-1:0]     position,
	input  logic [SLOT_W-1:0]    slot,
	input  logic                 prev_occ,
	input  logic                 nxt_occ,
	input  logic [KEY_WIDTH-1:0] nxt_entry,
	output logic                 occ,
	output logic [KEY_WIDTH-1:0] entry,
	output logic                 hit,
	output logic                 sel
);

	logic                 occ_q;
	logic [KEY_WIDTH-1:0] entry_q;
	logic                 hit_s1;
	logic                 sel_s1;
	logic                 take_ins;
	logic                 take_nxt;

	// this cell is the first free one, or lies at or above the removed slot
	assign take_ins = ctl.ins && !occ_q && prev_occ;
	assign take_nxt = ctl.rem && occ_q && (int'(slot) <= IDX);

	// occupancy flag, kept as a thermometer along the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (take_ins) begin
			occ_q <= 1'b1;
		end else if (take_nxt) begin
			occ_q <= nxt_occ;
		end
	end

	// stored key
	always_ff @(posedge clk) begin
		if (take_ins) begin
			entry_q <= ld_key;
		end else if (take_nxt) begin
			entry_q <= nxt_entry;
		end
	end

	// key compare and read-position match, latched with the request
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			hit_s1 <= occ_q && (entry_q == cmp_key);
			sel_s1 <= occ_q && (IDX < POS_SPAN) && (int'(position) == IDX);
		end
	end

	assign occ   = occ_q;
	assign entry = entry_q;
	assign hit   = hit_s1;
	assign sel   = sel_s1;

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for small_unordered_set, with its own model of the key set
// drives sus_req_if / sus_rsp_if and checks every response word; depends on sus_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
	import sus_pkg::*;

	localparam int SET_CAP      = CAPACITY_DEF;
	localparam int RANDOM_WORDS = 950;
	localparam int POOL_SIZE    = 24;
	localparam int IDLE_LIMIT   = 2000;
	localparam int MAX_SHOWN    = 10;

	typedef struct {
		sus_req_t word;
		bit       typed;
		sus_rsp_t rsp;
	} step_row_t;

	logic clk;
	logic arst_n;

	sus_req_if req ();
	sus_rsp_if rsp ();

	small_unordered_set dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// model of the set and the responses still owed
	logic [KEY_W-1:0] held_keys [SET_CAP];
	int               held_size;
	sus_rsp_t         rsp_due [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	step_row_t        steps [$];

	int err_count, shown, idle_cycles, checked_words, burst_left;
	int op_seen [4];
	int full_drops, range_reads, hits, peak_size;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic sus_req_t mk_req(mode_t m, logic [KEY_W-1:0] k, logic [POS_W-1:0] p);
		sus_req_t w;
		w.mode = m;
		w.key = k;
		w.position = p;
		return w;
	endfunction

	function automatic sus_rsp_t mk_rsp(logic f, logic [KEY_W-1:0] v, int n, status_t s);
		sus_rsp_t r;
		r.found = f;
		r.read_value = v;
		r.entry_count = n[CNT_OUT_W-1:0];
		r.status = s;
		return r;
	endfunction

	// append to the owed responses and to the directed rows
	function automatic void owe_rsp(sus_rsp_t r);
		rsp_due = {rsp_due, r};
	endfunction

	function automatic void add_step(step_row_t s);
		steps = {steps, s};
	endfunction

	// apply one operation to the held keys and return the response it owes
	function automatic sus_rsp_t set_update(sus_req_t w);
		sus_rsp_t r;
		int slot;
		int i;
		r = '0;
		slot = held_size;
		op_seen[int'(w.mode)]++;
		if (w.mode == MODE_READ) begin
			if (int'(w.position) < held_size) begin
				r.read_value = held_keys[w.position];
			end else begin
				r.status = STATUS_RANGE;
				range_reads++;
			end
		end else begin
			for (i = held_size - 1; i >= 0; i--)
				if (held_keys[i] == w.key)
					slot = i;
			r.found = (slot < held_size);
			if (r.found)
				hits++;
			if (w.mode == MODE_INSERT && !r.found) begin
				if (held_size < SET_CAP) begin
					held_keys[held_size] = w.key;
					held_size++;
				end else begin
					r.status = STATUS_FULL;
					full_drops++;
				end
			end else if (w.mode == MODE_REMOVE && r.found) begin
				// later keys move down one place to close the gap
				for (i = slot; i < held_size - 1; i++)
					held_keys[i] = held_keys[i + 1];
				held_size--;
			end
		end
		if (held_size > peak_size)
			peak_size = held_size;
		r.entry_count = held_size[CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic void note_error(string msg);
		err_count++;
		if (shown < MAX_SHOWN) begin
			shown++;
			$display("%0t ns: %s", $time, msg);
		end
	endfunction

	// mostly keys from a small pool so hits, full drops and removals happen often
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom();
	endfunction

	// sender pacing: bursts of random length with random gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
	endtask

	// present one word and hold it until it is taken
	task automatic send_word(sus_req_t w, bit typed, sus_rsp_t typed_rsp);
		sus_rsp_t r;
		pace();
		req.valid <= 1'b1;
		req.data <= w;
		do @(negedge clk); while (!req.ready);
		r = set_update(w);
		owe_rsp(typed ? typed_rsp : r);
		@(posedge clk);
	endtask

	// receiver: ready pattern steps through four styles in turn
	initial begin
		int cyc;
		int style;
		int stall_left;
		rsp.ready = 1'b0;
		cyc = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			cyc++;
			style = (cyc / 300) % 4;
			case (style)
				0: begin
					rsp.ready <= 1'b1;
				end
				1: begin
					rsp.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					rsp.ready <= ((cyc % 5) >= 2);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rsp.ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(4, 20);
						rsp.ready <= 1'b0;
					end else begin
						rsp.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// response check and watchdog, sampled mid-cycle
	always @(negedge clk) begin
		sus_rsp_t want;
		sus_rsp_t got;
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (rsp.valid && rsp.ready) begin
				checked_words++;
				got = rsp.data;
				if (rsp_due.size() == 0) begin
					note_error($sformatf({"response with none owed: found %0b",
						" value %h count %0d status %s"},
						got.found, got.read_value, got.entry_count,
						got.status.name()));
				end else begin
					want = rsp_due.pop_front();
					if (got.found !== want.found || got.read_value !== want.read_value ||
							got.entry_count !== want.entry_count ||
							got.status !== want.status)
						note_error($sformatf({"mismatch: expected found %0b",
							" value %h count %0d status %s,",
							" got found %0b value %h count %0d status %s"},
							want.found, want.read_value, want.entry_count,
							want.status.name(), got.found, got.read_value,
							got.entry_count, got.status.name()));
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles, %0d responses owed",
					idle_cycles, rsp_due.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		step_row_t s;
		int i;
		int n;
		int ins_pct;
		mode_t m;
		logic [POS_W-1:0] pos;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		held_size = 0;
		burst_left = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		// directed rows: typed expectation where it is obvious, model otherwise
		s.typed = 1'b1;
		s.word = mk_req(MODE_READ, '0, '0);
		s.rsp = mk_rsp(1'b0, '0, 0, STATUS_RANGE);
		add_step(s);
		s.word = mk_req(MODE_QUERY, '0, '0);
		s.rsp = mk_rsp(1'b0, '0, 0, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_REMOVE, '1, '1);
		s.rsp = mk_rsp(1'b0, '0, 0, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_INSERT, '0, '0);
		s.rsp = mk_rsp(1'b0, '0, 1, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_INSERT, '1, '0);
		s.rsp = mk_rsp(1'b0, '0, 2, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_INSERT, '0, '1);
		s.rsp = mk_rsp(1'b1, '0, 2, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_READ, 32'h1234_5678, 4'd1);
		s.rsp = mk_rsp(1'b0, '1, 2, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_READ, '0, '1);
		s.rsp = mk_rsp(1'b0, '0, 2, STATUS_RANGE);
		add_step(s);
		// fill the set up to capacity
		s.typed = 1'b0;
		s.rsp = '0;
		for (i = 0; i < SET_CAP - 2; i++) begin
			s.word = mk_req(MODE_INSERT, 32'hA5A5_0000 + i * 32'h0101, 4'(i));
			add_step(s);
		end
		s.typed = 1'b1;
		s.word = mk_req(MODE_INSERT, 32'hDEAD_BEEF, '0);
		s.rsp = mk_rsp(1'b0, '0, 16, STATUS_FULL);
		add_step(s);
		s.word = mk_req(MODE_INSERT, '0, '0);
		s.rsp = mk_rsp(1'b1, '0, 16, STATUS_OK);
		add_step(s);
		s.typed = 1'b0;
		s.word = mk_req(MODE_READ, '0, 4'd15); s.rsp = '0;
		add_step(s);
		s.typed = 1'b1;
		s.word = mk_req(MODE_REMOVE, '1, '0);
		s.rsp = mk_rsp(1'b1, '0, 15, STATUS_OK);
		add_step(s);
		s.typed = 1'b0;
		s.word = mk_req(MODE_READ, '0, 4'd1);  s.rsp = '0;
		add_step(s);
		s.typed = 1'b1;
		s.word = mk_req(MODE_QUERY, '1, '0);
		s.rsp = mk_rsp(1'b0, '0, 15, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_REMOVE, '0, '0);
		s.rsp = mk_rsp(1'b1, '0, 14, STATUS_OK);
		add_step(s);
		s.word = mk_req(MODE_READ, '0, 4'd14);
		s.rsp = mk_rsp(1'b0, '0, 14, STATUS_RANGE);
		add_step(s);

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[j])
			send_word(steps[j].word, steps[j].typed, steps[j].rsp);

		// random words, insert share changes every hundred words
		ins_pct = 50;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0)
				ins_pct = $urandom_range(20, 80);
			// hold off once until every owed response is back
			if (n == RANDOM_WORDS / 2) begin
				req.valid <= 1'b0;
				burst_left = 0;
				while (rsp_due.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			if ($urandom_range(0, 99) < ins_pct) begin
				m = MODE_INSERT;
			end else begin
				case ($urandom_range(0, 2))
					0: m = MODE_REMOVE;
					1: m = MODE_QUERY;
					default: m = MODE_READ;
				endcase
			end
			if ($urandom_range(0, 3) != 0 && held_size > 0)
				pos = POS_W'($urandom_range(0, held_size - 1));
			else
				pos = POS_W'($urandom_range(0, POS_SPAN - 1));
			send_word(mk_req(m, (m == MODE_READ) ? KEY_W'($urandom()) : pick_key(), pos),
				1'b0, '0);
		end
		req.valid <= 1'b0;

		// drain
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d words (%0d insert, %0d remove, %0d query, %0d read), %0d checked",
			steps.size() + RANDOM_WORDS, op_seen[MODE_INSERT], op_seen[MODE_REMOVE],
			op_seen[MODE_QUERY], op_seen[MODE_READ], checked_words);
		$display({"%0d key hits, %0d inserts dropped on a full set,",
			" %0d reads past the end, peak %0d"},
			hits, full_drops, range_reads, peak_size);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d failing responses", err_count);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/sus_pkg.sv
design/sus_req_if.sv
design/sus_rsp_if.sv
design/sus_cell.sv
design/small_unordered_set.sv
tb/testbench.sv
